/* rtl/core/fbd_pkg.sv */
package fbd_pkg;

    localparam int CLK_W      = 27;
    localparam int BAUD_W     = 24;
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 26;
    localparam int NUM_CELLS  = DIVIDEND_W;
    localparam int SCALED_W   = 19;
    localparam int MANT_W     = 12;
    localparam int FRAC_W     = 4;
    localparam int WORD_W     = 16;
    localparam int REM_W      = 7;

    localparam logic [CLK_W-1:0]      CLK_RESET   = 27'd16000000;
    localparam logic                  REG_CLK_HZ  = 1'b0;
    localparam logic                  REG_OVS8    = 1'b1;

    localparam logic [DIVIDEND_W-1:0] SAT_LIMIT   = 32'd409600;
    localparam logic [12:0]           RECIP_100   = 13'd5242;
    localparam int                    RECIP_SHIFT = 19;
    localparam logic [10:0]           RECIP_FRAC  = 11'd1311;
    localparam int                    FRAC_SHIFT  = 17;
    localparam logic [6:0]            SCALE       = 7'd100;
    localparam logic [10:0]           HALF        = 11'd50;
    localparam logic [FRAC_W-1:0]     MASK_BY8    = 4'h7;
    localparam logic [FRAC_W-1:0]     MASK_BY16   = 4'hF;
    localparam logic [MANT_W:0]       MANT_MAX    = 13'd4095;
    localparam logic [WORD_W-1:0]     WORD_SAT    = 16'hFFFF;

    typedef struct packed {
        logic [DIVISOR_W-1:0]  rem;
        logic [DIVIDEND_W-1:0] nq;
        logic [DIVISOR_W-1:0]  dvs;
        logic                  by8;
    } fbd_div_t;

endpackage

/* rtl/core/fbd_div_cell.sv */
module fbd_div_cell
    import fbd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  fbd_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output fbd_div_t out_data
);

    logic                 valid_reg;
    fbd_div_t             data_reg;
    fbd_div_t             data_next;
    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   dvs_ext;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    assign rem_sh  = {in_data.rem, in_data.nq[DIVIDEND_W-1]};
    assign dvs_ext = {1'b0, in_data.dvs};
    assign diff    = rem_sh - dvs_ext;
    assign ge      = rem_sh >= dvs_ext;

    always_comb begin
        data_next     = in_data;
        data_next.rem = ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        data_next.nq  = {in_data.nq[DIVIDEND_W-2:0], ge};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/core/fbd_post.sv */
module fbd_post
    import fbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DIVIDEND_W-1:0] in_quot,
    input  logic                  in_by8,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORD_W-1:0]     out_word,
    output logic                  out_flag
);

    logic                  va_reg, vb_reg, vc_reg;
    logic                  rdy_a, rdy_b, rdy_c;

    logic                  sat_a_reg, by8_a_reg;
    logic [SCALED_W-1:0]   s_a_reg;
    logic [MANT_W-1:0]     mest_a_reg;
    logic [DIVIDEND_W-1:0] prod_a;

    logic                  sat_b_reg, by8_b_reg;
    logic [MANT_W-1:0]     mant_b_reg, mant_b_next;
    logic [REM_W-1:0]      rem_b_reg, rem_b_next;
    logic [SCALED_W-1:0]   r_b;

    logic [WORD_W-1:0]     word_reg, word_next;
    logic                  flag_reg, flag_next;
    logic [10:0]           x_c;
    logic [21:0]           prod_c;
    logic [FRAC_W:0]       f_c;
    logic [FRAC_W:0]       steps_c;
    logic [MANT_W:0]       mant_c;
    logic [FRAC_W-1:0]     frac_c;

    assign rdy_c    = !vc_reg || out_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    assign prod_a = DIVIDEND_W'(in_quot[SCALED_W-1:0]) * DIVIDEND_W'(RECIP_100);

    always_comb begin
        r_b = s_a_reg - SCALED_W'(mest_a_reg) * SCALED_W'(SCALE);
        if (r_b >= SCALED_W'(SCALE)) begin
            mant_b_next = mest_a_reg + 1'b1;
            rem_b_next  = REM_W'(r_b - SCALED_W'(SCALE));
        end else begin
            mant_b_next = mest_a_reg;
            rem_b_next  = REM_W'(r_b);
        end
    end

    always_comb begin
        x_c     = by8_b_reg ? {1'b0, rem_b_reg, 3'b000} + HALF : {rem_b_reg, 4'b0000} + HALF;
        prod_c  = 22'(x_c) * 22'(RECIP_FRAC);
        f_c     = prod_c[FRAC_SHIFT+FRAC_W:FRAC_SHIFT];
        steps_c = by8_b_reg ? 5'd8 : 5'd16;
        mant_c  = {1'b0, mant_b_reg};
        frac_c  = f_c[FRAC_W-1:0];
        if (f_c >= steps_c) begin
            mant_c = mant_c + 1'b1;
            frac_c = '0;
        end
        if (sat_b_reg || mant_c > MANT_MAX) begin
            word_next = WORD_SAT;
            flag_next = 1'b1;
        end else begin
            word_next = {mant_c[MANT_W-1:0], frac_c & (by8_b_reg ? MASK_BY8 : MASK_BY16)};
            flag_next = mant_c == '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (rdy_a) va_reg <= in_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
        end
        if (rdy_a && in_valid) begin
            sat_a_reg  <= in_quot >= SAT_LIMIT;
            by8_a_reg  <= in_by8;
            s_a_reg    <= in_quot[SCALED_W-1:0];
            mest_a_reg <= prod_a[RECIP_SHIFT+MANT_W-1:RECIP_SHIFT];
        end
        if (rdy_b && va_reg) begin
            sat_b_reg  <= sat_a_reg;
            by8_b_reg  <= by8_a_reg;
            mant_b_reg <= mant_b_next;
            rem_b_reg  <= rem_b_next;
        end
        if (rdy_c && vb_reg) begin
            word_reg <= word_next;
            flag_reg <= flag_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_word  = word_reg;
    assign out_flag  = flag_reg;

endmodule

/* rtl/core/fractional_baud_divisor.sv */
// Channel  | Handshake         | Payload
// s_       | s_valid, s_ready  | s_baud_rate[23:0]
// m_       | m_valid, m_ready  | m_divisor_word[15:0], m_mantissa[11:0], m_fraction[3:0],
//          |                   | m_out_of_range
// cfg_     | cfg_wr_en         | cfg_addr (0 clock Hz, 1 oversample by 8), cfg_wdata[26:0]
//
// One item per cycle unless the output stalls: 32 restoring divider cells, one quotient
// bit each, then three stages that split by 100, round the fraction and pack the word.
// Each stage holds its own valid bit, so bubbles close up while the output stalls.
// Synchronous active-low reset empties the pipe and loads 16 MHz, oversampling by 16.
module fractional_baud_divisor
    import fbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [CLK_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BAUD_W-1:0]  s_baud_rate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_divisor_word,
    output logic [MANT_W-1:0]  m_mantissa,
    output logic [FRAC_W-1:0]  m_fraction,
    output logic               m_out_of_range
);

    logic [CLK_W-1:0]  clk_hz_reg;
    logic              ovs8_reg;

    logic              cell_valid [NUM_CELLS+1];
    logic              cell_ready [NUM_CELLS+1];
    fbd_div_t          cell_data  [NUM_CELLS+1];
    logic [DIVIDEND_W-1:0] clk_ext;
    logic [WORD_W-1:0] word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= CLK_RESET;
            ovs8_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CLK_HZ: clk_hz_reg <= cfg_wdata;
                REG_OVS8:   ovs8_reg   <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    assign clk_ext = DIVIDEND_W'(clk_hz_reg);

    always_comb begin
        cell_data[0].rem = '0;
        cell_data[0].nq  = (clk_ext << 4) + (clk_ext << 3) + clk_ext;
        cell_data[0].dvs = ovs8_reg ? {1'b0, s_baud_rate, 1'b0} : {s_baud_rate, 2'b00};
        cell_data[0].by8 = ovs8_reg;
    end

    assign cell_valid[0] = s_valid;
    assign s_ready       = cell_ready[0];

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        fbd_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    fbd_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cell_valid[NUM_CELLS]),
        .in_ready  (cell_ready[NUM_CELLS]),
        .in_quot   (cell_data[NUM_CELLS].nq),
        .in_by8    (cell_data[NUM_CELLS].by8),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (word),
        .out_flag  (m_out_of_range)
    );

    assign m_divisor_word = word;
    assign m_mantissa     = word[WORD_W-1:FRAC_W];
    assign m_fraction     = word[FRAC_W-1:0];

endmodule
